// ===== hdl/tlbfl_pkg.sv =====
// tlbfl_pkg: shared types and codes of the fully associative tlb
// opcodes, register indexes, controller states and the control/status bundles
// no dependencies
`timescale 1ns / 1ps

package tlbfl_pkg;

  localparam int LIMIT_BITS = 5;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  localparam logic [0:0] CFG_MODE  = 1'b0;
  localparam logic [0:0] CFG_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_SELECT,
    S_EVICT,
    S_PLACE,
    S_FLUSH,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic select;
    logic evict;
    logic place;
    logic flush_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic flush_last;
  } stat_t;

endpackage

// ===== hdl/tlbfl_ctrl.sv =====
// tlbfl_ctrl: sequencing state machine of the tlb
// depends on tlbfl_pkg (state_t, op_t, cmd_t, stat_t)
`timescale 1ns / 1ps

module tlbfl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  tlbfl_pkg::op_t   in_op,
  output logic             in_stall,
  input  tlbfl_pkg::stat_t st,
  output tlbfl_pkg::cmd_t  cmd
);
  import tlbfl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_op)
            OP_LOOKUP: state_next = S_MATCH;
            OP_INSERT: state_next = S_EVICT;
            OP_FLUSH:  state_next = S_FLUSH;
            default:   state_next = S_RESULT;
          endcase
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_SELECT;
      end
      S_SELECT: begin
        cmd.select = 1'b1;
        state_next = S_RESULT;
      end
      S_EVICT: begin
        cmd.evict  = 1'b1;
        state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_RESULT;
      end
      S_FLUSH: begin
        cmd.flush_step = 1'b1;
        if (st.flush_last) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tlbfl_dp.sv =====
// tlbfl_dp: entry storage, match logic, rank bookkeeping and result register
// depends on tlbfl_pkg (cmd_t, stat_t, MODE_LRU, LIMIT_BITS)
`timescale 1ns / 1ps

module tlbfl_dp #(
  parameter int ENTRIES    = 16,
  parameter int PROC_BITS  = 16,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           replace_mode,
  input  logic [tlbfl_pkg::LIMIT_BITS-1:0] entries_in_use,
  input  tlbfl_pkg::cmd_t                cmd,
  output tlbfl_pkg::stat_t               st,
  input  logic [PROC_BITS-1:0]           proc_id,
  input  logic [PAGE_BITS-1:0]           page_num,
  input  logic [FRAME_BITS-1:0]          frame_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic [FRAME_BITS-1:0]          frame_out
);
  import tlbfl_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

  logic [ENTRIES-1:0]    valid;
  logic [IW-1:0]         rank [ENTRIES];
  logic [CW-1:0]         valid_count;
  logic [PROC_BITS-1:0]  entry_proc  [ENTRIES];
  logic [PAGE_BITS-1:0]  entry_page  [ENTRIES];
  logic [FRAME_BITS-1:0] entry_frame [ENTRIES];

  logic [PROC_BITS-1:0]  q_proc;
  logic [PAGE_BITS-1:0]  q_page;
  logic [FRAME_BITS-1:0] q_frame;
  logic [ENTRIES-1:0]    match;
  logic                  res_hit;
  logic [FRAME_BITS-1:0] res_frame;
  logic [IW-1:0]         flush_idx;

  logic [LW-1:0]         lim;
  logic [LW-1:0]         limit_ext;
  logic [LW-1:0]         vc_ext;
  logic [LW-1:0]         drop_w;
  logic [CW-1:0]         drop;
  logic                  enabled;
  logic                  full;
  logic [ENTRIES-1:0]    match_now;
  logic [ENTRIES-1:0]    older;
  logic [ENTRIES-1:0]    sel;
  logic                  any_hit;
  logic [IW-1:0]         best_rank;
  logic [FRAME_BITS-1:0] sel_frame;
  logic [IW-1:0]         newest;
  logic                  free_found;
  logic [IW-1:0]         free_idx;
  logic                  gone_k;
  logic [IW-1:0]         rank_k;

  // usable limit and eviction amount
  always_comb begin
    limit_ext = LW'(entries_in_use);
    lim       = (limit_ext > LW'(ENTRIES)) ? LW'(ENTRIES) : limit_ext;
    enabled   = (lim != '0);
    vc_ext    = LW'(valid_count);
    full      = (vc_ext >= lim);
    drop_w    = vc_ext - lim + LW'(1);
    drop      = full ? CW'(drop_w) : '0;
    newest    = IW'(valid_count - CW'(1));
  end

  // key compare across all entries
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_now[i] = valid[i] && (entry_proc[i] == q_proc) && (entry_page[i] == q_page);
    end
  end

  // oldest matching entry
  always_comb begin
    best_rank = '0;
    sel_frame = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      older[i] = 1'b0;
      for (int j = 0; j < ENTRIES; j++) begin
        if (match[j] && (rank[j] < rank[i])) begin
          older[i] = 1'b1;
        end
      end
      sel[i] = match[i] && !older[i];
      if (sel[i]) begin
        best_rank = best_rank | rank[i];
        sel_frame = sel_frame | entry_frame[i];
      end
    end
    any_hit = |match;
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign gone_k = valid[flush_idx] && (entry_proc[flush_idx] == q_proc);
  assign rank_k = rank[flush_idx];

  assign st.out_free   = !out_valid || !out_stall;
  assign st.flush_last = (flush_idx == IW'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      valid_count <= '0;
      flush_idx   <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end
      if (cmd.capture) begin
        flush_idx <= '0;
      end
      // lru promotion of the hit entry
      if (cmd.select && enabled && any_hit && (replace_mode == MODE_LRU)) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (sel[i]) begin
            rank[i] <= newest;
          end else if (valid[i] && (rank[i] > best_rank)) begin
            rank[i] <= rank[i] - IW'(1);
          end
        end
      end
      // drop oldest entries to make room
      if (cmd.evict && enabled && full) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i]) begin
            if (CW'(rank[i]) < drop) begin
              valid[i] <= 1'b0;
              rank[i]  <= '0;
            end else begin
              rank[i] <= rank[i] - IW'(drop);
            end
          end
        end
        valid_count <= valid_count - drop;
      end
      if (cmd.place && enabled && free_found) begin
        valid[free_idx] <= 1'b1;
        rank[free_idx]  <= IW'(valid_count);
        valid_count     <= valid_count + CW'(1);
      end
      // one entry per cycle, younger entries close the gap
      if (cmd.flush_step) begin
        flush_idx <= flush_idx + IW'(1);
        if (gone_k) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid[i] && (rank[i] > rank_k)) begin
              rank[i] <= rank[i] - IW'(1);
            end
          end
          valid[flush_idx] <= 1'b0;
          rank[flush_idx]  <= '0;
          valid_count      <= valid_count - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_proc    <= proc_id;
      q_page    <= page_num;
      q_frame   <= frame_in;
      res_hit   <= 1'b0;
      res_frame <= '0;
    end
    if (cmd.match) begin
      match <= match_now;
    end
    if (cmd.select && enabled && any_hit) begin
      res_hit   <= 1'b1;
      res_frame <= sel_frame;
    end
    if (cmd.place && enabled && free_found) begin
      entry_proc[free_idx]  <= q_proc;
      entry_page[free_idx]  <= q_page;
      entry_frame[free_idx] <= q_frame;
    end
    if (cmd.emit) begin
      hit       <= res_hit;
      frame_out <= res_frame;
    end
  end

endmodule

// ===== hdl/tlb_fifo_lru.sv =====
// tlb_fifo_lru: fully associative tlb with fifo or lru replacement
// depends on tlbfl_pkg, tlbfl_ctrl, tlbfl_dp
//
//   channel  handshake            payload
//   in       in_valid / in_stall  opcode, proc_id, page_num, frame_in
//   out      out_valid / out_stall hit, frame_out
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// lookup runs match, select, result; insert runs evict, place, result; a no-op goes
// straight to result; flush walks all entries, one entry per cycle; one transaction in flight;
// the finished result waits in the output register while the next transaction is accepted
// rst is synchronous: tlb empty, fifo mode, entry limit 16 (all entries at the default size)
`timescale 1ns / 1ps

module tlb_fifo_lru #(
  parameter int ENTRIES    = 16,
  parameter int PROC_BITS  = 16,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       opcode,
  input  logic [PROC_BITS-1:0]             proc_id,
  input  logic [PAGE_BITS-1:0]             page_num,
  input  logic [FRAME_BITS-1:0]            frame_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output logic [FRAME_BITS-1:0]            frame_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_index,
  input  logic [tlbfl_pkg::LIMIT_BITS-1:0] cfg_data
);
  import tlbfl_pkg::*;

  logic                  replace_mode;
  logic [LIMIT_BITS-1:0] entries_in_use;
  cmd_t                  cmd;
  stat_t                 st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_mode   <= MODE_FIFO;
      entries_in_use <= LIMIT_BITS'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:  replace_mode   <= cfg_data[0];
        CFG_LIMIT: entries_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tlbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (op_t'(opcode)),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  tlbfl_dp #(
    .ENTRIES    (ENTRIES),
    .PROC_BITS  (PROC_BITS),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .replace_mode   (replace_mode),
    .entries_in_use (entries_in_use),
    .cmd            (cmd),
    .st             (st),
    .proc_id        (proc_id),
    .page_num       (page_num),
    .frame_in       (frame_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .frame_out      (frame_out)
  );

endmodule

// ===== sim/tlb_fifo_lru_test.sv =====
// tlb_fifo_lru_test: self-checking testbench for the fifo/lru tlb
// random bursts of translation requests checked against a local tlb predictor
// depends on tlbfl_pkg and tlb_fifo_lru
`timescale 1ns / 1ps

module tlb_fifo_lru_test;
  import tlbfl_pkg::*;

  localparam int TLB_ENTRIES = 16;
  localparam int PROC_W = 16;
  localparam int PAGE_W = 20;
  localparam int FRAME_W = 20;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int PHASES = 18;
  localparam int FIXED_PHASES = 10;
  localparam int OPS_PER_PHASE = 95;

  localparam logic PHASE_MODE [FIXED_PHASES] = '{
    MODE_LRU, MODE_FIFO, MODE_LRU, MODE_FIFO, MODE_LRU,
    MODE_FIFO, MODE_LRU, MODE_LRU, MODE_FIFO, MODE_LRU
  };
  localparam logic [LIMIT_BITS-1:0] PHASE_LIMIT [FIXED_PHASES] = '{
    5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd16, 5'd0
  };

  typedef struct {
    op_t               op;
    logic [PROC_W-1:0]  pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlb_req_t;

  typedef struct {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlb_ans_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_TOGGLE, STALL_HEAVY} stall_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = OP_NOP;
  logic [PROC_W-1:0] proc_id = '0;
  logic [PAGE_W-1:0] page_num = '0;
  logic [FRAME_W-1:0] frame_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [FRAME_W-1:0] frame_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = CFG_MODE;
  logic [LIMIT_BITS-1:0] cfg_data = '0;

  tlb_fifo_lru dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .proc_id(proc_id), .page_num(page_num), .frame_in(frame_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .frame_out(frame_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // predicted tlb contents and configuration
  logic                tlb_valid [TLB_ENTRIES];
  logic [PROC_W-1:0]   tlb_proc  [TLB_ENTRIES];
  logic [PAGE_W-1:0]   tlb_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0]  tlb_frame [TLB_ENTRIES];
  int                  tlb_rank  [TLB_ENTRIES];
  int                  tlb_count = 0;
  logic                cfg_mode = MODE_FIFO;
  logic [LIMIT_BITS-1:0] cfg_limit = 5'd16;

  tlb_req_t tlb_ops_todo[$];
  tlb_ans_t tlb_answers[$];

  int ops_queued = 0;
  int answered = 0;
  int ops_taken = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int cfg_writes = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int hold_request = 0;
  int hold_served = 0;
  logic in_fire = 1'b0;

  initial begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tlb_valid[i] = 1'b0;
      tlb_proc[i] = '0;
      tlb_page[i] = '0;
      tlb_frame[i] = '0;
      tlb_rank[i] = 0;
    end
  end

  function automatic void tlb_apply(input tlb_req_t r, output tlb_ans_t a);
    int found, best, lim, drop, kept, slot;
    logic gone [TLB_ENTRIES];
    int new_rank [TLB_ENTRIES];
    a.hit = 1'b0;
    a.frame = '0;
    lim = (cfg_limit > TLB_ENTRIES) ? TLB_ENTRIES : int'(cfg_limit);
    case (r.op)
      OP_LOOKUP: begin
        found = -1;
        best = 0;
        if (lim != 0) begin
          for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (tlb_valid[i] && tlb_proc[i] == r.pid && tlb_page[i] == r.page &&
                (found < 0 || tlb_rank[i] < best)) begin
              found = i;
              best = tlb_rank[i];
            end
          end
        end
        if (found >= 0) begin
          a.hit = 1'b1;
          a.frame = tlb_frame[found];
          if (cfg_mode == MODE_LRU) begin
            for (int i = 0; i < TLB_ENTRIES; i++)
              if (tlb_valid[i] && tlb_rank[i] > best) tlb_rank[i]--;
            tlb_rank[found] = tlb_count - 1;
          end
        end
      end
      OP_INSERT: begin
        if (lim != 0) begin
          if (tlb_count >= lim) begin
            // evict the oldest entries so the new one lands at the limit
            drop = tlb_count - lim + 1;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
              if (tlb_valid[i]) begin
                if (tlb_rank[i] < drop) begin
                  tlb_valid[i] = 1'b0;
                  tlb_rank[i] = 0;
                end else begin
                  tlb_rank[i] -= drop;
                end
              end
            end
            tlb_count -= drop;
          end
          slot = -1;
          for (int i = 0; i < TLB_ENTRIES; i++)
            if (!tlb_valid[i] && slot < 0) slot = i;
          if (slot >= 0) begin
            tlb_valid[slot] = 1'b1;
            tlb_proc[slot] = r.pid;
            tlb_page[slot] = r.page;
            tlb_frame[slot] = r.frame;
            tlb_rank[slot] = tlb_count;
            tlb_count++;
          end
        end
      end
      OP_FLUSH: begin
        kept = 0;
        for (int i = 0; i < TLB_ENTRIES; i++)
          gone[i] = tlb_valid[i] && tlb_proc[i] == r.pid;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          new_rank[i] = 0;
          if (tlb_valid[i] && !gone[i]) begin
            for (int j = 0; j < TLB_ENTRIES; j++)
              if (tlb_valid[j] && !gone[j] && tlb_rank[j] < tlb_rank[i]) new_rank[i]++;
            kept++;
          end
        end
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (gone[i]) begin
            tlb_valid[i] = 1'b0;
            tlb_rank[i] = 0;
          end else if (tlb_valid[i]) begin
            tlb_rank[i] = new_rank[i];
          end
        end
        tlb_count = kept;
      end
      default: ;
    endcase
  endfunction

  // request driver: bursts of transactions with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    logic busy;
    tlb_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid && !in_fire;
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (tlb_ops_todo.size() != 0) begin
          nxt = tlb_ops_todo.pop_front();
          opcode <= nxt.op;
          proc_id <= nxt.pid;
          page_num <= nxt.page;
          frame_in <= nxt.frame;
          busy = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid <= busy;
    end
  end

  // result receiver: changing stall style plus an occasional long hold-off
  int hold_left = 0;
  int style_left = 0;
  stall_style_t stall_style = STALL_NONE;

  always @(negedge clk) begin
    logic stall_now;
    if (hold_served != hold_request) begin
      hold_served = hold_request;
      hold_left = LONG_HOLD;
    end
    if (style_left == 0) begin
      style_left = $urandom_range(20, 120);
      stall_style = stall_style_t'($urandom_range(0, 3));
    end else begin
      style_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_now = 1'b1;
    end else begin
      case (stall_style)
        STALL_LIGHT:  stall_now = ($urandom_range(0, 3) == 0);
        STALL_TOGGLE: stall_now = !out_stall;
        STALL_HEAVY:  stall_now = ($urandom_range(0, 3) != 0);
        default:      stall_now = 1'b0;
      endcase
    end
    out_stall <= stall_now;
  end

  // monitor: predicts on each accepted request, checks each accepted result
  always @(posedge clk) begin
    tlb_req_t r;
    tlb_ans_t a;
    logic any_fire;
    in_fire = !rst && in_valid && !in_stall;
    any_fire = in_fire;
    if (!rst && out_valid && !out_stall) begin
      any_fire = 1'b1;
      results_seen++;
      if (tlb_answers.size() == 0) begin
        $error("result with no request outstanding: hit %0b frame_out %h", hit, frame_out);
        errors++;
      end else begin
        a = tlb_answers.pop_front();
        answered++;
        if (hit !== a.hit) begin
          $error("hit: expected %0b, got %0b", a.hit, hit);
          errors++;
        end
        if (frame_out !== a.frame) begin
          $error("frame_out: expected %h, got %h", a.frame, frame_out);
          errors++;
        end
        if (a.hit) hits_seen++;
      end
    end
    if (in_fire) begin
      r.op = op_t'(opcode);
      r.pid = proc_id;
      r.page = page_num;
      r.frame = frame_in;
      tlb_apply(r, a);
      tlb_answers.push_back(a);
      ops_taken++;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      any_fire = 1'b1;
      cfg_writes++;
      if (cfg_index == CFG_MODE) cfg_mode = cfg_data[0];
      else cfg_limit = cfg_data;
    end
    if (rst || any_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, tlb_answers.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic queue_op(input op_t op, input logic [PROC_W-1:0] pid,
                          input logic [PAGE_W-1:0] page, input logic [FRAME_W-1:0] frame);
    tlb_req_t r;
    r.op = op;
    r.pid = pid;
    r.page = page;
    r.frame = frame;
    tlb_ops_todo.push_back(r);
    ops_queued++;
  endtask

  task automatic wait_all_answered();
    do @(negedge clk); while (answered != ops_queued);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [LIMIT_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [PROC_W-1:0] pids [4];
    logic [PAGE_W-1:0] pages [6];
    logic mode_sel;
    logic [LIMIT_BITS-1:0] limit_sel;
    logic [LIMIT_BITS-1:0] mode_word;
    int kind;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings (fifo, all entries), field extremes, duplicates, flush
    queue_op(OP_LOOKUP, '0, '0, '0);
    queue_op(OP_NOP, '1, '1, '1);
    queue_op(OP_INSERT, '0, '0, '0);
    queue_op(OP_INSERT, '1, '1, '1);
    queue_op(OP_LOOKUP, '0, '0, '1);
    queue_op(OP_LOOKUP, '1, '1, '0);
    queue_op(OP_LOOKUP, '1, '0, '0);
    queue_op(OP_LOOKUP, '0, '1, '0);
    queue_op(OP_INSERT, '0, '0, 20'h12345);
    queue_op(OP_LOOKUP, '0, '0, '0);
    queue_op(OP_FLUSH, '1, '0, '0);
    queue_op(OP_LOOKUP, '1, '1, '0);
    queue_op(OP_LOOKUP, '0, '0, '0);
    queue_op(OP_FLUSH, '0, '1, '1);
    queue_op(OP_LOOKUP, '0, '0, '0);
    queue_op(OP_FLUSH, 16'h1234, '0, '0);
    queue_op(OP_INSERT, 16'h0001, 20'h5, 20'haaaaa);
    queue_op(OP_INSERT, 16'h0002, 20'h5, 20'h55555);
    queue_op(OP_LOOKUP, 16'h0002, 20'h5, '0);
    queue_op(OP_LOOKUP, 16'h0001, 20'h5, '0);
    queue_op(OP_NOP, '0, '0, '0);
    wait_all_answered();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < FIXED_PHASES) begin
        mode_sel = PHASE_MODE[ph];
        limit_sel = PHASE_LIMIT[ph];
        mode_word = {4'b0, mode_sel};
      end else begin
        mode_sel = 1'($urandom_range(0, 1));
        limit_sel = ($urandom_range(0, 3) == 0) ? LIMIT_BITS'($urandom_range(0, 31)) :
                                                  LIMIT_BITS'($urandom_range(1, 16));
        mode_word = {4'($urandom_range(0, 15)), mode_sel};
      end
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_MODE, mode_word);
        write_reg(CFG_LIMIT, limit_sel);
      end else begin
        write_reg(CFG_LIMIT, limit_sel);
        write_reg(CFG_MODE, mode_word);
      end
      // block fills and stalls its input while results are held back
      if (ph == 2) hold_request++;

      for (int i = 0; i < 4; i++) pids[i] = PROC_W'($urandom);
      for (int i = 0; i < 6; i++) pages[i] = PAGE_W'($urandom);

      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 10)
          queue_op(op_t'($urandom_range(0, 3)), PROC_W'($urandom), PAGE_W'($urandom),
                   FRAME_W'($urandom));
        else if (kind < 50)
          queue_op(OP_LOOKUP, pids[$urandom_range(0, 3)], pages[$urandom_range(0, 5)],
                   FRAME_W'($urandom));
        else if (kind < 82)
          queue_op(OP_INSERT, pids[$urandom_range(0, 3)], pages[$urandom_range(0, 5)],
                   FRAME_W'($urandom));
        else if (kind < 92)
          queue_op(OP_FLUSH, pids[$urandom_range(0, 3)], PAGE_W'($urandom),
                   FRAME_W'($urandom));
        else if (kind < 96)
          queue_op(OP_NOP, PROC_W'($urandom), PAGE_W'($urandom), FRAME_W'($urandom));
        else
          queue_op(OP_LOOKUP, pids[$urandom_range(0, 3)], PAGE_W'($urandom),
                   FRAME_W'($urandom));
      end
      wait_all_answered();
    end

    repeat (40) @(posedge clk);

    $display("Ran %0d translation requests (%0d hits among %0d results)",
             ops_taken, hits_seen, results_seen);
    $display("over %0d fifo/lru and entry-limit settings using %0d register writes",
             PHASES + 1, cfg_writes);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
